>>> hw/rtl/tal_pkg.sv
// shared types and constants of the thresholded argmax labeler
// no dependencies
package tal_pkg;

  localparam int SCORE_W     = 16;
  localparam int CLASS_W     = 8;
  localparam int INDEX_W     = 16;
  localparam int CFG_DATA_W  = 17;
  localparam int CFG_INDEX_W = 2;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_ORDERING    = 2'd0,
    REG_CLASS_COUNT = 2'd1,
    REG_PIXEL_COUNT = 2'd2,
    REG_THRESHOLD   = 2'd3
  } cfg_reg_t;

  localparam logic [CLASS_W:0]    CLASS_COUNT_RESET = 9'd2;
  localparam int                  PIXEL_COUNT_RESET = 65536;
  localparam logic [SCORE_W-1:0]  THRESHOLD_RESET   = 16'd2048;

  // one classified word on its way from front to back
  typedef struct packed {
    logic               chw;
    logic               first;
    logic               emit;
    logic               frame_last;
    logic [CLASS_W-1:0] cls;
    logic [SCORE_W-1:0] score;
  } tag_t;

  typedef struct packed {
    logic [CLASS_W-1:0] cls;
    logic [SCORE_W-1:0] score;
  } best_t;

endpackage

>>> hw/rtl/thresholded_argmax_labeler.sv
// thresholded argmax labeler: one score per cycle unless stalled, one label per pixel
// scores pass the queue and the update stage; labels are held in an output register
// throughput: 1 score per cycle unless m_tready stalls, set by one read and one write
// per cycle of the per-pixel best memory (CHW) or the running best register (HWC)
// reset: synchronous rst restores register defaults and clears counters and queue;
// the per-pixel memory is not cleared, plane 0 writes every entry first
module thresholded_argmax_labeler #(
  parameter int MAX_PIXELS  = 65536,
  parameter int MAX_CLASSES = 256
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [tal_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [tal_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [15:0]                         s_tdata,  // score[15:0]
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [23:0]                         m_tdata,  // label[7:0], pixel_index[23:8]
  output logic                                m_tlast   // frame_last
);
  import tal_pkg::*;

  localparam int PIX_W = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
  localparam int QW    = $bits(tag_t) + PIX_W;

  logic               accept;
  tag_t               push_tag;
  logic [PIX_W-1:0]   push_pix;
  logic [SCORE_W-1:0] threshold;
  logic               q_full;
  logic               q_not_empty;
  logic               q_pop;
  logic [QW-1:0]      q_head;
  tag_t               q_tag;
  logic [PIX_W-1:0]   q_pix;
  logic [CLASS_W-1:0] label;
  logic [INDEX_W-1:0] pixel_index;

  assign s_tready = !q_full;
  assign accept   = s_tvalid && s_tready;

  tal_front #(
    .MAX_PIXELS  (MAX_PIXELS),
    .MAX_CLASSES (MAX_CLASSES)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .score     (s_tdata),
    .push_tag  (push_tag),
    .push_pix  (push_pix),
    .threshold (threshold)
  );

  tal_queue #(
    .W (QW)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_data ({push_tag, push_pix}),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  assign q_tag = q_head[QW-1:PIX_W];
  assign q_pix = q_head[PIX_W-1:0];

  tal_back #(
    .MAX_PIXELS (MAX_PIXELS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .threshold   (threshold),
    .q_valid     (q_not_empty),
    .q_tag       (q_tag),
    .q_pix       (q_pix),
    .pop         (q_pop),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .label       (label),
    .pixel_index (pixel_index),
    .frame_last  (m_tlast)
  );

  assign m_tdata = {pixel_index, label};

endmodule

>>> hw/rtl/tal_front.sv
// front part: configuration registers, class and pixel counters, word tagging
// depends on tal_pkg
module tal_front #(
  parameter int MAX_PIXELS  = 65536,
  parameter int MAX_CLASSES = 256
) (
  input  logic                                              clk,
  input  logic                                              rst,
  input  logic                                              cfg_we,
  input  logic [tal_pkg::CFG_INDEX_W-1:0]                   cfg_index,
  input  logic [tal_pkg::CFG_DATA_W-1:0]                    cfg_data,
  input  logic                                              accept,
  input  logic [tal_pkg::SCORE_W-1:0]                       score,
  output tal_pkg::tag_t                                     push_tag,
  output logic [((MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1)-1:0] push_pix,
  output logic [tal_pkg::SCORE_W-1:0]                       threshold
);
  import tal_pkg::*;

  localparam int PIX_W = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
  localparam int PIX_RESET_LAST =
    ((MAX_PIXELS < PIXEL_COUNT_RESET) ? MAX_PIXELS : PIXEL_COUNT_RESET) - 1;
  localparam logic [CLASS_W:0] CLASS_RESET_LAST = CLASS_COUNT_RESET - 9'd1;

  logic               ordering;
  logic [CLASS_W-1:0] class_last;
  logic [PIX_W-1:0]   pixel_last;
  logic [CLASS_W-1:0] class_counter;
  logic [PIX_W-1:0]   pixel_counter;
  logic               last_class;
  logic               last_pixel;

  function automatic logic [CLASS_W-1:0] class_limit(input logic [CFG_DATA_W-1:0] v);
    logic [CLASS_W:0] c;
    logic [CLASS_W:0] m;
    c = v[CLASS_W:0];
    m = c - 9'd1;
    if (c == '0) return '0;
    else if (int'(c) > MAX_CLASSES) return CLASS_W'(MAX_CLASSES - 1);
    else return m[CLASS_W-1:0];
  endfunction

  function automatic logic [PIX_W-1:0] pixel_limit(input logic [CFG_DATA_W-1:0] v);
    logic [CFG_DATA_W-1:0] m;
    m = v - 17'd1;
    if (v == '0) return '0;
    else if (int'(v) > MAX_PIXELS) return PIX_W'(MAX_PIXELS - 1);
    else return PIX_W'(m);
  endfunction

  assign last_class = class_counter >= class_last;
  assign last_pixel = pixel_counter >= pixel_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      ordering      <= 1'b0;
      class_last    <= CLASS_RESET_LAST[CLASS_W-1:0];
      pixel_last    <= PIX_W'(PIX_RESET_LAST);
      threshold     <= THRESHOLD_RESET;
      class_counter <= '0;
      pixel_counter <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_ORDERING:    ordering   <= cfg_data[0];
        REG_CLASS_COUNT: class_last <= class_limit(cfg_data);
        REG_PIXEL_COUNT: pixel_last <= pixel_limit(cfg_data);
        REG_THRESHOLD:   threshold  <= cfg_data[SCORE_W-1:0];
        default:         ordering   <= ordering;
      endcase
      class_counter <= '0;
      pixel_counter <= '0;
    end else if (accept) begin
      if (!ordering) begin
        if (last_class) begin
          class_counter <= '0;
          pixel_counter <= last_pixel ? '0 : pixel_counter + 1'b1;
        end else begin
          class_counter <= class_counter + 1'b1;
        end
      end else begin
        if (last_pixel) begin
          pixel_counter <= '0;
          class_counter <= last_class ? '0 : class_counter + 1'b1;
        end else begin
          pixel_counter <= pixel_counter + 1'b1;
        end
      end
    end
  end

  always_comb begin
    push_tag.chw        = ordering;
    push_tag.first      = (class_counter == '0);
    push_tag.emit       = last_class;
    push_tag.frame_last = last_pixel;
    push_tag.cls        = class_counter;
    push_tag.score      = score;
  end

  assign push_pix = pixel_counter;

  a_class_in_range: assert property (@(posedge clk) disable iff (rst)
    class_counter <= class_last)
    else $error("class counter past configured class count");

  a_pixel_in_range: assert property (@(posedge clk) disable iff (rst)
    pixel_counter <= pixel_last)
    else $error("pixel counter past configured pixel count");

  a_cfg_restarts: assert property (@(posedge clk) disable iff (rst)
    cfg_we |=> (class_counter == '0) && (pixel_counter == '0))
    else $error("register write did not restart the frame");

endmodule

>>> hw/rtl/tal_queue.sv
// short queue of tagged words between front and back
// depends on tal_pkg
module tal_queue #(
  parameter int W = 32
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] push_data,
  output logic         full,
  input  logic         pop,
  output logic         not_empty,
  output logic [W-1:0] head
);
  import tal_pkg::*;

  logic [W-1:0]      slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr;
  logic [QPTR_W-1:0] rptr;
  logic [QPTR_W:0]   count;

  assign full      = (count == (QPTR_W + 1)'(QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign head      = slots[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= wptr + 1'b1;
      if (pop) rptr <= rptr + 1'b1;
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !full)
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> not_empty)
    else $error("queue read while empty");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (QPTR_W + 1)'(QUEUE_DEPTH))
    else $error("queue count out of range");

endmodule

>>> hw/rtl/tal_back.sv
// back part: best-score update, per-pixel best memory, output register
// depends on tal_pkg
module tal_back #(
  parameter int MAX_PIXELS = 65536
) (
  input  logic                                              clk,
  input  logic                                              rst,
  input  logic [tal_pkg::SCORE_W-1:0]                       threshold,
  input  logic                                              q_valid,
  input  tal_pkg::tag_t                                     q_tag,
  input  logic [((MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1)-1:0] q_pix,
  output logic                                              pop,
  output logic                                              m_tvalid,
  input  logic                                              m_tready,
  output logic [tal_pkg::CLASS_W-1:0]                       label,
  output logic [tal_pkg::INDEX_W-1:0]                       pixel_index,
  output logic                                              frame_last
);
  import tal_pkg::*;

  localparam int PIX_W = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;

  best_t            plane_best [MAX_PIXELS];
  best_t            rd_val;
  best_t            run_best;
  best_t            fwd_val;
  best_t            cur;
  best_t            nxt;
  logic             s1_valid;
  tag_t             s1_tag;
  logic [PIX_W-1:0] s1_pix;
  logic             s1_fwd;
  logic             adv;
  logic             wr;
  logic             hit;
  logic             take;
  logic             done;

  assign adv  = !s1_valid || !s1_tag.emit || !m_tvalid || m_tready;
  assign pop  = q_valid && adv;
  assign done = s1_valid && adv;
  assign wr   = done && s1_tag.chw;
  assign hit  = pop && wr && (s1_pix == q_pix);

  always_comb begin
    cur  = s1_tag.chw ? (s1_fwd ? fwd_val : rd_val) : run_best;
    take = s1_tag.first ||
           (($signed(s1_tag.score) > $signed(threshold)) &&
            ($signed(s1_tag.score) > $signed(cur.score)));
    nxt  = cur;
    if (take) begin
      nxt.score = s1_tag.score;
      nxt.cls   = s1_tag.first ? '0 : s1_tag.cls;
    end
  end

  // read-modify-write, a write to the address being read is forwarded
  always_ff @(posedge clk) begin
    if (wr) plane_best[s1_pix] <= nxt;
    if (pop) rd_val <= plane_best[q_pix];
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      s1_tag  <= q_tag;
      s1_pix  <= q_pix;
      s1_fwd  <= hit;
      fwd_val <= nxt;
    end
    if (done && s1_tag.emit && (!m_tvalid || m_tready)) begin
      label       <= nxt.cls;
      pixel_index <= INDEX_W'(s1_pix);
      frame_last  <= s1_tag.frame_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      m_tvalid <= 1'b0;
      run_best <= '0;
    end else begin
      if (adv) s1_valid <= pop;
      if (done && !s1_tag.chw) run_best <= nxt;
      if (done && s1_tag.emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !adv) |=> s1_valid && $stable(s1_pix) && $stable(s1_tag))
    else $error("stalled word in update stage changed");

  a_no_pop_on_stall: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s1_tag.emit && m_tvalid && !m_tready) |-> !pop && !wr)
    else $error("update stage moved while output held");

  a_label_loaded: assert property (@(posedge clk) disable iff (rst)
    (done && s1_tag.emit) |=> m_tvalid)
    else $error("finished label not presented");

endmodule

>>> bench/tb_top.sv
// testbench for thresholded_argmax_labeler: directed rows, then random phases
// checked word by word against fixed plan words or an in-bench argmax predictor
// depends on tal_pkg and the thresholded_argmax_labeler rtl
`timescale 1ns / 1ps

module tb_top;
  import tal_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;

  typedef struct packed {
    logic                frame_last;
    logic [INDEX_W-1:0]  pixel_index;
    logic [CLASS_W-1:0]  label;
  } label_word_t;

  typedef enum logic [1:0] {PREDICT, NO_LABEL, LABEL} check_kind_t;

  typedef struct {
    bit          is_cfg;
    cfg_reg_t    reg_sel;
    logic [16:0] value;
    check_kind_t check;
    label_word_t want;
  } plan_row_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [15:0]            s_tdata = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [23:0]            m_tdata;
  logic                   m_tlast;

  // predictor copy of registers and state
  logic                      chw_cfg = 1'b0;
  logic [CLASS_W:0]          cls_cfg = CLASS_COUNT_RESET;
  logic [16:0]               pix_cfg = 17'(PIXEL_COUNT_RESET);
  logic signed [SCORE_W-1:0] thr_cfg = THRESHOLD_RESET;
  logic signed [SCORE_W-1:0] run_score = '0;
  logic [CLASS_W-1:0]        run_cls = '0;
  int unsigned               cls_ctr = 0;
  int unsigned               pix_ctr = 0;
  logic signed [SCORE_W-1:0] plane_score [65536];
  logic [CLASS_W-1:0]        plane_cls [65536];

  label_word_t expected_labels [$];
  int          mismatches = 0;
  int          stalled_cycles = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;

  plan_row_t plan [0:32] = '{
    '{1'b0, REG_ORDERING,    17'h08000, NO_LABEL, '0},
    '{1'b0, REG_ORDERING,    17'h07FFF, LABEL,    '{1'b0, 16'd0, 8'd1}},
    '{1'b0, REG_ORDERING,    17'h00000, NO_LABEL, '0},
    '{1'b0, REG_ORDERING,    17'h00800, LABEL,    '{1'b0, 16'd1, 8'd0}},
    '{1'b0, REG_ORDERING,    17'h00801, NO_LABEL, '0},
    '{1'b0, REG_ORDERING,    17'h00801, LABEL,    '{1'b0, 16'd2, 8'd0}},
    '{1'b0, REG_ORDERING,    17'h00800, NO_LABEL, '0},
    '{1'b0, REG_ORDERING,    17'h00801, LABEL,    '{1'b0, 16'd3, 8'd1}},
    '{1'b1, REG_THRESHOLD,   17'h18000, PREDICT,  '0},
    '{1'b1, REG_CLASS_COUNT, 17'h00000, PREDICT,  '0},
    '{1'b1, REG_PIXEL_COUNT, 17'd3,     PREDICT,  '0},
    '{1'b0, REG_ORDERING,    17'h01234, LABEL,    '{1'b0, 16'd0, 8'd0}},
    '{1'b0, REG_ORDERING,    17'h0FFFF, LABEL,    '{1'b0, 16'd1, 8'd0}},
    '{1'b0, REG_ORDERING,    17'h05555, LABEL,    '{1'b1, 16'd2, 8'd0}},
    '{1'b1, REG_ORDERING,    17'h1FFFF, PREDICT,  '0},
    '{1'b1, REG_CLASS_COUNT, 17'd3,     PREDICT,  '0},
    '{1'b1, REG_PIXEL_COUNT, 17'd2,     PREDICT,  '0},
    '{1'b1, REG_THRESHOLD,   17'h00000, PREDICT,  '0},
    '{1'b0, REG_ORDERING,    17'h00100, NO_LABEL, '0},
    '{1'b0, REG_ORDERING,    17'h0FF00, NO_LABEL, '0},
    '{1'b0, REG_ORDERING,    17'h00100, NO_LABEL, '0},
    '{1'b0, REG_ORDERING,    17'h00001, NO_LABEL, '0},
    '{1'b0, REG_ORDERING,    17'h00200, PREDICT,  '0},
    '{1'b0, REG_ORDERING,    17'h08000, PREDICT,  '0},
    '{1'b1, REG_PIXEL_COUNT, 17'h00000, PREDICT,  '0},
    '{1'b0, REG_ORDERING,    17'h07FFF, NO_LABEL, '0},
    '{1'b0, REG_ORDERING,    17'h07FFF, NO_LABEL, '0},
    '{1'b0, REG_ORDERING,    17'h00001, PREDICT,  '0},
    '{1'b1, REG_ORDERING,    17'h1FFFE, PREDICT,  '0},
    '{1'b1, REG_CLASS_COUNT, 17'h1FE01, PREDICT,  '0},
    '{1'b1, REG_PIXEL_COUNT, 17'h1FFFF, PREDICT,  '0},
    '{1'b0, REG_ORDERING,    17'h0A5A5, PREDICT,  '0},
    '{1'b0, REG_ORDERING,    17'h05A5A, PREDICT,  '0}
  };

  thresholded_argmax_labeler DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

  always #5 clk = ~clk;

  // advances the predicted state by one score, returns 1 when a label word is due
  function automatic bit classify_score(input logic [15:0] raw, output label_word_t w);
    logic signed [SCORE_W-1:0] s;
    int unsigned nc, np;
    bit last_cls, last_pix;
    s = raw;
    nc = (cls_cfg == 0) ? 1 : (cls_cfg > 256) ? 256 : cls_cfg;
    np = (pix_cfg == 0) ? 1 : (pix_cfg > 65536) ? 65536 : pix_cfg;
    last_cls = (cls_ctr + 1 >= nc);
    last_pix = (pix_ctr + 1 >= np);
    w = '0;
    w.pixel_index = pix_ctr[15:0];
    w.frame_last = last_pix;
    if (!chw_cfg) begin
      if (cls_ctr == 0) begin
        run_score = s;
        run_cls = '0;
      end else if (s > thr_cfg && s > run_score) begin
        run_score = s;
        run_cls = cls_ctr[7:0];
      end
      if (!last_cls) begin
        cls_ctr++;
        return 1'b0;
      end
      cls_ctr = 0;
      w.label = run_cls;
      pix_ctr = last_pix ? 0 : pix_ctr + 1;
      return 1'b1;
    end
    if (cls_ctr == 0) begin
      plane_score[pix_ctr] = s;
      plane_cls[pix_ctr] = '0;
    end else if (s > thr_cfg && s > plane_score[pix_ctr]) begin
      plane_score[pix_ctr] = s;
      plane_cls[pix_ctr] = cls_ctr[7:0];
    end
    w.label = plane_cls[pix_ctr];
    if (last_pix) begin
      pix_ctr = 0;
      cls_ctr = last_cls ? 0 : cls_ctr + 1;
    end else begin
      pix_ctr++;
    end
    return last_cls;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch on %s: got %0d, expected %0d at %0t", what, got, want, $time);
    mismatches++;
  endtask

  task automatic send_score(input logic [15:0] sc, output bit has, output label_word_t w);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= sc;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    has = classify_score(sc, w);
  endtask

  // hold the sender until every label word is back and the pipeline is empty
  task automatic settle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_labels.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t r, input logic [16:0] v);
    settle();
    cfg_we <= 1'b1;
    cfg_index <= r;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (r)
      REG_ORDERING:    chw_cfg = v[0];
      REG_CLASS_COUNT: cls_cfg = v[8:0];
      REG_PIXEL_COUNT: pix_cfg = v;
      REG_THRESHOLD:   thr_cfg = v[15:0];
    endcase
    cls_ctr = 0;
    pix_ctr = 0;
    @(posedge clk);
  endtask

  // output side: random stall and compare against the oldest expectation
  always @(posedge clk) begin
    label_word_t want;
    m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    if (!rst && m_tvalid && m_tready) begin
      if (expected_labels.size() == 0) begin
        report_mismatch("unexpected word, pixel_index", 32'(m_tdata[23:8]), 32'hFFFF_FFFF);
      end else begin
        want = expected_labels.pop_front();
        if (m_tdata[7:0] !== want.label)
          report_mismatch("label", 32'(m_tdata[7:0]), 32'(want.label));
        if (m_tdata[23:8] !== want.pixel_index)
          report_mismatch("pixel_index", 32'(m_tdata[23:8]), 32'(want.pixel_index));
        if (m_tlast !== want.frame_last)
          report_mismatch("frame_last", 32'(m_tlast), 32'(want.frame_last));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
      stalled_cycles <= 0;
    end else if (stalled_cycles >= WATCHDOG_LIMIT) begin
      $display("thresholded_argmax_labeler test failed");
      $finish;
    end else begin
      stalled_cycles <= stalled_cycles + 1;
    end
  end

  initial begin
    bit          has;
    label_word_t w;
    int          n_items;
    int          thr_i;
    logic [8:0]  cls;
    logic [16:0] pix;
    logic [15:0] sc;
    logic [15:0] last_sc;
    last_sc = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        write_reg(plan[i].reg_sel, plan[i].value);
      end else begin
        send_score(plan[i].value[15:0], has, w);
        case (plan[i].check)
          PREDICT: if (has) expected_labels.push_back(w);
          LABEL:   expected_labels.push_back(plan[i].want);
          default: ;
        endcase
      end
    end

    for (int ph = 0; ph < 16; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 62; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 62; end
        default: begin send_idle_pct = 33; recv_stall_pct = 33; end
      endcase
      n_items = $urandom_range(44, 60);
      if (ph == 3) begin
        cls = 9'd256;
        pix = 17'($urandom_range(1, 2));
        n_items = 260;
      end else if (ph == 11) begin
        cls = 9'($urandom_range(257, 511));
        pix = 17'($urandom_range(1, 2));
        n_items = 260;
      end else begin
        cls = ($urandom_range(0, 9) == 0) ? 9'd0 : 9'($urandom_range(1, 6));
        case ($urandom_range(0, 7))
          0:       pix = 17'd0;
          1:       pix = 17'($urandom_range(65536, 131071));
          default: pix = 17'($urandom_range(1, 8));
        endcase
      end
      case ($urandom_range(0, 3))
        0:       thr_i = $urandom_range(0, 17'h1FFFF);
        1:       thr_i = $urandom_range(0, 1) ? 32'h0000_7FFF : 32'h0001_8000;
        default: thr_i = $urandom_range(0, 8191) - 4096;
      endcase
      write_reg(REG_ORDERING, {16'($urandom), ph[3] ^ ph[2]});
      write_reg(REG_CLASS_COUNT, {8'($urandom), cls});
      write_reg(REG_PIXEL_COUNT, pix);
      write_reg(REG_THRESHOLD, 17'(thr_i));
      for (int k = 0; k < n_items; k++) begin
        if ($urandom_range(0, 99) == 0) settle();
        case ($urandom_range(0, 5))
          0, 1:    sc = 16'($urandom);
          2:       sc = thr_cfg + 16'($urandom_range(0, 4)) - 16'd2;
          3:       sc = last_sc;
          4:       sc = last_sc + 16'd1;
          default: sc = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
        endcase
        last_sc = sc;
        send_score(sc, has, w);
        if (has) expected_labels.push_back(w);
      end
    end

    settle();
    if (mismatches == 0) begin
      $display("thresholded_argmax_labeler test passed");
    end else begin
      $display("thresholded_argmax_labeler test failed");
    end
    $finish;
  end

endmodule

>>> thresholded_argmax_labeler.f
hw/rtl/tal_pkg.sv
hw/rtl/tal_front.sv
hw/rtl/tal_queue.sv
hw/rtl/tal_back.sv
hw/rtl/thresholded_argmax_labeler.sv
bench/tb_top.sv
